// ===== rtl/tngs_pkg.sv =====
// Shared types and constants for the timed note gate scheduler.
package tngs_pkg;

  // Outputs driven by one expander.
  localparam int OUTS_PER_EXP = 16;
  // Multiplier bits retired one per cycle by the due check.
  localparam int MUL_STEPS = 16;

  // One input item.
  typedef struct packed {
    logic [31:0] elapsed_ms;
    logic        event_valid;
    logic [15:0] event_timestamp;
    logic [7:0]  event_note;
  } item_t;

  // One result item.
  typedef struct packed {
    logic        event_taken;
    logic [1:0]  note_status;
    logic [31:0] output_image;
    logic        any_active;
  } result_t;

  // Note status codes.
  localparam logic [1:0] NOTE_NONE    = 2'd0;
  localparam logic [1:0] NOTE_APPLIED = 2'd1;
  localparam logic [1:0] NOTE_RANGE   = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MULT      = 3'd0;
  localparam logic [2:0] CFG_DIV       = 3'd1;
  localparam logic [2:0] CFG_TRANSPOSE = 3'd2;
  localparam logic [2:0] CFG_HOLD      = 3'd3;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DUE,
    S_APPLY,
    S_SWEEP,
    S_DRAIN,
    S_DONE
  } state_t;

  // Status from the due check back to the sequencer.
  typedef struct packed {
    logic done;
    logic due;
  } due_status_t;

endpackage

// ===== rtl/tngs_due.sv =====
// Bit-serial due check: elapsed > stamp*mult/div, done as elapsed*div > stamp*mult.
module tngs_due
  import tngs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] elapsed_ms,
  input  logic [15:0] timestamp,
  input  logic [15:0] multiplier,
  input  logic [15:0] divider,
  output due_status_t status
);

  localparam int STEP_W = $clog2(MUL_STEPS + 1);

  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic              done;
  logic              due;

  // stamp * mult, one multiplier bit a cycle
  logic [31:0] p_acc;
  logic [31:0] p_mcand;
  logic [15:0] p_bits;
  // elapsed * div, one multiplier bit a cycle
  logic [47:0] q_acc;
  logic [47:0] q_mcand;
  logic [15:0] q_bits;

  logic last_step;
  assign last_step = (cnt == STEP_W'(MUL_STEPS));

  // Control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (last_step) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // Datapath: shift-add for both products, compare at the end
  always_ff @(posedge clk) begin
    if (start) begin
      p_acc   <= '0;
      p_mcand <= {16'd0, multiplier};
      p_bits  <= timestamp;
      q_acc   <= '0;
      q_mcand <= {16'd0, elapsed_ms};
      // a zero divider counts as one
      q_bits  <= (divider == 16'd0) ? 16'd1 : divider;
    end else if (busy) begin
      if (last_step) begin
        due <= (q_acc > {16'd0, p_acc});
      end else begin
        if (p_bits[0]) p_acc <= p_acc + p_mcand;
        if (q_bits[0]) q_acc <= q_acc + q_mcand;
        p_mcand <= {p_mcand[30:0], 1'b0};
        q_mcand <= {q_mcand[46:0], 1'b0};
        p_bits  <= {1'b0, p_bits[15:1]};
        q_bits  <= {1'b0, q_bits[15:1]};
      end
    end
  end

  assign status.done = done;
  assign status.due  = due;

endmodule

// ===== rtl/timed_note_gate_scheduler_unit.sv =====
// Top level of the timed note gate scheduler: sequencer, off-time store, output gates.
//
//  channel   direction  handshake               payload
//  item      in         item_valid/item_stall   item (item_t)
//  result    out        result_valid/result_stall result (result_t)
//  cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// Each item passes through the bit-serial due check (16 multiplier bits), the
// note apply, then a sweep of the off-time memory through its single read
// port, one output at a time, and a drain. Reset is synchronous; it clears the
// control state, valid bits and gate image, and loads the configuration defaults.
// The next item is taken while a result waits; a stalled result holds the
// sequencer in its last state until the transfer goes through.
module timed_note_gate_scheduler_unit
  import tngs_pkg::*;
#(
  parameter int NUM_EXPANDERS = 2,
  parameter int LOWEST_NOTE   = 60
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int NUM_OUT = OUTS_PER_EXP * NUM_EXPANDERS;
  localparam int IDX_W   = $clog2(NUM_OUT);
  localparam int HI_NOTE = LOWEST_NOTE + NUM_OUT - 1;

  // Configuration registers
  logic [15:0] tempo_multiplier;
  logic [15:0] tempo_divider;
  logic [7:0]  transpose;
  logic [15:0] hold_time;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      tempo_multiplier <= 16'd1;
      tempo_divider    <= 16'd1;
      transpose        <= 8'd0;
      hold_time        <= 16'd100;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MULT:      tempo_multiplier <= cfg_data;
        CFG_DIV:       tempo_divider    <= cfg_data;
        CFG_TRANSPOSE: transpose        <= cfg_data[7:0];
        CFG_HOLD:      hold_time        <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Sequencer
  state_t state, state_next;
  logic   item_xfer;
  logic   due_start;
  logic   apply_en;
  logic   sweep_rd;
  logic   result_load;
  logic   out_free;

  logic [IDX_W-1:0] sweep_cnt;
  logic             sweep_last;
  due_status_t      due_st;

  assign item_xfer  = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign sweep_last = (sweep_cnt == IDX_W'(NUM_OUT - 1));

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (item_valid) state_next = S_DUE;
      S_DUE:   if (due_st.done) state_next = S_APPLY;
      S_APPLY: state_next = S_SWEEP;
      S_SWEEP: if (sweep_last) state_next = S_DRAIN;
      S_DRAIN: state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    item_stall  = 1'b1;
    due_start   = 1'b0;
    apply_en    = 1'b0;
    sweep_rd    = 1'b0;
    result_load = 1'b0;
    case (state)
      S_IDLE: begin
        item_stall = rst;
        due_start  = item_valid && !rst;
      end
      S_APPLY: apply_en = 1'b1;
      S_SWEEP: sweep_rd = 1'b1;
      S_DONE:  result_load = out_free;
      default: ;
    endcase
  end

  // Current item
  item_t cur;
  always_ff @(posedge clk) begin
    if (item_xfer) cur <= item;
  end

  tngs_due u_due (
    .clk        (clk),
    .rst        (rst),
    .start      (due_start),
    .elapsed_ms (item.elapsed_ms),
    .timestamp  (item.event_timestamp),
    .multiplier (tempo_multiplier),
    .divider    (tempo_divider),
    .status     (due_st)
  );

  logic due_ok;
  always_ff @(posedge clk) begin
    if (due_st.done) due_ok <= due_st.due;
  end

  // Note transpose and range check
  logic [7:0]       note;
  logic             in_range;
  logic             taken;
  logic [IDX_W-1:0] note_idx;

  assign note     = cur.event_note + transpose;
  assign in_range = ({1'b0, note} >= 9'(LOWEST_NOTE)) && ({1'b0, note} <= 9'(HI_NOTE));
  assign taken    = cur.event_valid && due_ok;
  assign note_idx = IDX_W'(note - 8'(LOWEST_NOTE));

  logic       taken_r;
  logic [1:0] status_r;
  always_ff @(posedge clk) begin
    if (apply_en) begin
      taken_r  <= taken;
      status_r <= !taken ? NOTE_NONE : (in_range ? NOTE_APPLIED : NOTE_RANGE);
    end
  end

  // Off-time memory, one write and one registered read port
  logic [31:0]      off_mem [NUM_OUT];
  logic             mem_we;
  logic [31:0]      rd_data;
  logic             rd_vld;
  logic             rd_pend;
  logic [IDX_W-1:0] rd_idx;
  logic [NUM_OUT-1:0] vld;

  assign mem_we = apply_en && taken && in_range;

  always_ff @(posedge clk) begin
    if (mem_we) off_mem[note_idx] <= cur.elapsed_ms + {16'd0, hold_time};
    if (sweep_rd) begin
      rd_data <= off_mem[sweep_cnt];
      rd_vld  <= vld[sweep_cnt];
      rd_idx  <= sweep_cnt;
    end
  end

  // Sweep address counter
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
      rd_pend   <= 1'b0;
    end else begin
      rd_pend <= sweep_rd;
      if (apply_en)      sweep_cnt <= '0;
      else if (sweep_rd) sweep_cnt <= sweep_cnt + 1'b1;
    end
  end

  // Entries never written read as an off time of zero
  logic [31:0] rd_off;
  assign rd_off = rd_vld ? rd_data : 32'd0;

  // Gate image and valid bits
  logic [NUM_OUT-1:0] image;
  always_ff @(posedge clk) begin
    if (rst) begin
      image <= '0;
      vld   <= '0;
    end else begin
      if (mem_we) begin
        image[note_idx] <= 1'b1;
        vld[note_idx]   <= 1'b1;
      end
      if (rd_pend && (cur.elapsed_ms > rd_off)) image[rd_idx] <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result.event_taken  <= taken_r;
      result.note_status  <= status_r;
      result.output_image <= 32'(image);
      result.any_active   <= |image;
    end
  end

  // Checks
  a_result_after_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> result_valid)
    else $error("finished item did not reach the output register");

  a_status_matches_taken: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.event_taken == (result.note_status != NOTE_NONE)))
    else $error("note status disagrees with event_taken");

  a_due_done_in_due: assert property (@(posedge clk) disable iff (rst)
    due_st.done |-> (state == S_DUE))
    else $error("due check finished outside its wait state");

  a_write_only_on_apply: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> (state == S_SWEEP && sweep_cnt == '0))
    else $error("off-time write not followed by a fresh sweep");

endmodule

// ===== tb/timed_note_gate_scheduler_unit_tb.sv =====
// Self-checking testbench for the timed note gate scheduler: directed table, then random playback.
`timescale 1ns / 100ps

module timed_note_gate_scheduler_unit_tb
  import tngs_pkg::*;
();

  localparam int NUM_EXP     = 2;
  localparam int LOW_NOTE    = 60;
  localparam int NUM_OUTS    = OUTS_PER_EXP * NUM_EXP;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 200;
  localparam int LONG_HOLD   = 400;
  localparam int MAX_REPORTS = 10;

  // Block ports
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  item_t       item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_MULT;
  logic [15:0] cfg_data = '0;

  // Shadow of the configuration registers
  logic [15:0] cfg_mult;
  logic [15:0] cfg_div;
  logic [7:0]  cfg_shift;
  logic [15:0] cfg_hold;

  // Predicted gate state
  logic [31:0] off_ms [NUM_OUTS];
  logic [31:0] gate_bits;

  // Expected results, oldest first
  result_t gate_exp [$];
  result_t gate_want;

  // Stimulus and idling control
  logic [31:0] now_ms;
  int snd_pct = 0;
  int rcv_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int err_count = 0;
  int cyc_count = 0;

  typedef struct {
    item_t   stim;
    bit      known;
    result_t want;
  } dir_row_t;

  typedef struct {
    logic [15:0] mult;
    logic [15:0] div;
    logic [7:0]  shift;
    logic [15:0] hold;
    int          snd;
    int          rcv;
    bit          squeeze;
    int          count;
  } phase_t;

  dir_row_t dir_tab [$];
  phase_t   phases [7];

  timed_note_gate_scheduler_unit #(
    .NUM_EXPANDERS(NUM_EXP),
    .LOWEST_NOTE(LOW_NOTE)
  ) uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cyc_count <= cyc_count + 1;
    if (cyc_count >= CYCLE_LIMIT) begin
      $display("timed_note_gate_scheduler_unit_tb: done, errors");
      $finish;
    end
  end

  // Gate predictor: due check, note apply, then expiry sweep
  function automatic result_t gate_predict(item_t it);
    logic [31:0] due_ms;
    logic [31:0] eff_div;
    logic [7:0]  note;
    result_t     r;
    int          idx;
    eff_div = (cfg_div == 16'd0) ? 32'd1 : 32'(cfg_div);
    due_ms = (32'(it.event_timestamp) * 32'(cfg_mult)) / eff_div;
    r = '0;
    r.note_status = NOTE_NONE;
    if (it.event_valid && it.elapsed_ms > due_ms) begin
      note = it.event_note + cfg_shift;
      r.event_taken = 1'b1;
      if (note >= LOW_NOTE && note <= LOW_NOTE + NUM_OUTS - 1) begin
        idx = note - LOW_NOTE;
        off_ms[idx] = it.elapsed_ms + 32'(cfg_hold);
        gate_bits[idx] = 1'b1;
        r.note_status = NOTE_APPLIED;
      end else begin
        r.note_status = NOTE_RANGE;
      end
    end
    for (int i = 0; i < NUM_OUTS; i++) begin
      if (it.elapsed_ms > off_ms[i]) gate_bits[i] = 1'b0;
    end
    r.output_image = gate_bits;
    r.any_active = |gate_bits;
    return r;
  endfunction

  // Random item: mostly song playback near the due boundary, some noise
  function automatic item_t song_item();
    item_t       it;
    int          pick;
    int          target;
    int          delta;
    longint      ts;
    logic [15:0] dv;
    it = '0;
    pick = $urandom_range(99);
    it.event_valid = ($urandom_range(9) != 0);
    if (pick < 78) begin
      if ($urandom_range(49) == 0) now_ms = $urandom_range(0, 3000);
      else if ($urandom_range(19) == 0) now_ms = now_ms + $urandom_range(0, 2 * cfg_hold + 100);
      else now_ms = now_ms + $urandom_range(0, 40);
      it.elapsed_ms = now_ms;
      target = ($urandom_range(7) == 0) ? $urandom_range(0, 255)
                                        : LOW_NOTE + $urandom_range(0, NUM_OUTS - 1);
      it.event_note = 8'(target) - cfg_shift;
      dv = (cfg_div == 16'd0) ? 16'd1 : cfg_div;
      if (cfg_mult == 16'd0) ts = $urandom_range(0, 65535);
      else ts = (longint'(now_ms) * longint'(dv)) / longint'(cfg_mult);
      delta = int'($urandom_range(0, 4)) - 2;
      ts = ts + delta;
      if (ts < 0) ts = 0;
      if (ts > 65535) ts = 65535;
      it.event_timestamp = 16'(ts);
    end else begin
      it.elapsed_ms = $urandom;
      if (pick >= 96) it.elapsed_ms = 32'hFFFF_FFC0 | 32'($urandom_range(0, 63));
      it.event_timestamp = 16'($urandom);
      it.event_note = 8'($urandom);
    end
    return it;
  endfunction

  // Offer one item; on transfer, record the expected result
  task automatic send_item(input item_t it, input bit known, input result_t want);
    result_t pred;
    while (snd_pct != 0 && $urandom_range(99) < snd_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pred = gate_predict(it);
    gate_exp.push_back(known ? want : pred);
    @(negedge clk);
  endtask

  // One register write; updates the shadow on transfer
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MULT:      cfg_mult = data;
      CFG_DIV:       cfg_div = data;
      CFG_TRANSPOSE: cfg_shift = data[7:0];
      CFG_HOLD:      cfg_hold = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic add_row(input logic [31:0] el, input logic vld, input logic [15:0] ts,
                         input logic [7:0] note, input bit known, input result_t want);
    dir_row_t row;
    row.stim = '0;
    row.stim.elapsed_ms = el;
    row.stim.event_valid = vld;
    row.stim.event_timestamp = ts;
    row.stim.event_note = note;
    row.known = known;
    row.want = want;
    dir_tab.push_back(row);
  endtask

  // Receiver: random stall, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= (rcv_pct != 0) && ($urandom_range(99) < rcv_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (gate_exp.size() == 0) begin
        if (err_count < MAX_REPORTS)
          $display("unexpected result transfer: %h", result);
        err_count = err_count + 1;
      end else begin
        gate_want = gate_exp.pop_front();
        if (result.event_taken !== gate_want.event_taken ||
            result.note_status !== gate_want.note_status ||
            result.output_image !== gate_want.output_image ||
            result.any_active !== gate_want.any_active) begin
          if (err_count < MAX_REPORTS)
            $display("mismatch: taken %b/%b status %0d/%0d image %h/%h active %b/%b (exp/got)",
                     gate_want.event_taken, result.event_taken,
                     gate_want.note_status, result.note_status,
                     gate_want.output_image, result.output_image,
                     gate_want.any_active, result.any_active);
          err_count = err_count + 1;
        end
      end
    end
  end

  initial begin
    phase_t ph;
    // Reset state of the shadow and predictor
    cfg_mult = 16'd1;
    cfg_div = 16'd1;
    cfg_shift = 8'd0;
    cfg_hold = 16'd100;
    for (int i = 0; i < NUM_OUTS; i++) off_ms[i] = '0;
    gate_bits = '0;
    now_ms = '0;

    // Directed table, reset configuration
    add_row(32'd0, 1'b0, 16'd0, 8'd60, 1, '{1'b0, NOTE_NONE, 32'd0, 1'b0});
    // elapsed equal to due time is not due
    add_row(32'd0, 1'b1, 16'd0, 8'd60, 1, '{1'b0, NOTE_NONE, 32'd0, 1'b0});
    add_row(32'd1, 1'b1, 16'd0, 8'd60, 1, '{1'b1, NOTE_APPLIED, 32'd1, 1'b1});
    // off time wraps below elapsed: set and cleared in one step
    add_row(32'hFFFF_FFFF, 1'b1, 16'hFFFF, 8'd91, 1, '{1'b1, NOTE_APPLIED, 32'd0, 1'b0});
    // notes just outside the range, and the note extremes
    add_row(32'd5, 1'b1, 16'd4, 8'd59, 1, '{1'b1, NOTE_RANGE, 32'd0, 1'b0});
    add_row(32'd10, 1'b1, 16'd9, 8'd92, 1, '{1'b1, NOTE_RANGE, 32'd0, 1'b0});
    add_row(32'd20, 1'b1, 16'd19, 8'hFF, 1, '{1'b1, NOTE_RANGE, 32'd0, 1'b0});
    add_row(32'd21, 1'b1, 16'd20, 8'h00, 1, '{1'b1, NOTE_RANGE, 32'd0, 1'b0});
    add_row(32'd1000, 1'b1, 16'd1000, 8'd75, 0, '0);
    add_row(32'd1001, 1'b1, 16'd1000, 8'd75, 0, '0);
    add_row(32'd1010, 1'b1, 16'h0155, 8'd62, 0, '0);
    add_row(32'd1020, 1'b1, 16'h02AA, 8'd91, 0, '0);
    add_row(32'd1050, 1'b0, 16'hFFFF, 8'd60, 0, '0);
    add_row(32'd1101, 1'b1, 16'd1100, 8'hAA, 0, '0);
    add_row(32'd1102, 1'b0, 16'd0, 8'd0, 0, '0);
    add_row(32'd1200, 1'b0, 16'd0, 8'd0, 0, '0);
    add_row(32'h8000_0000, 1'b1, 16'h8000, 8'd60, 0, '0);
    // elapsed going backwards keeps the note on
    add_row(32'h7FFF_FFFF, 1'b1, 16'd0, 8'd90, 0, '0);
    add_row(32'h8000_0063, 1'b1, 16'h5555, 8'd61, 0, '0);
    add_row(32'h8000_0065, 1'b0, 16'd0, 8'd0, 0, '0);

    // Playback phases: mult, div, transpose, hold, sender idle, receiver stall, long hold-off, item count
    phases[0] = '{16'd1, 16'd1, 8'h00, 16'd100, 0, 0, 1'b0, 300};
    phases[1] = '{16'hFFFF, 16'hFFFF, 8'h80, 16'd0, 46, 0, 1'b0, 300};
    phases[2] = '{16'd3, 16'd7, 8'h7F, 16'hFFFF, 0, 46, 1'b0, 300};
    phases[3] = '{16'hFFFF, 16'd1, 8'h0C, 16'd250, 20, 20, 1'b0, 300};
    // zero divider acts as one
    phases[4] = '{16'd1, 16'd0, 8'hC4, 16'd500, 0, 0, 1'b1, 300};
    phases[5] = '{16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  8'($urandom), 16'($urandom_range(0, 65535)), 20, 20, 1'b0, 250};
    phases[6] = '{16'd1000, 16'hFFFF, 8'hFF, 16'd40, 46, 0, 1'b0, 200};

    // Hold synchronous reset, then release it
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[i]) send_item(dir_tab[i].stim, dir_tab[i].known, dir_tab[i].want);
    item_valid <= 1'b0;

    foreach (phases[p]) begin
      ph = phases[p];
      // registers change only with nothing in flight
      while (gate_exp.size() != 0) @(negedge clk);
      write_reg(CFG_MULT, ph.mult);
      write_reg(CFG_DIV, ph.div);
      write_reg(CFG_TRANSPOSE, {8'd0, ph.shift});
      write_reg(CFG_HOLD, ph.hold);
      cfg_valid <= 1'b0;
      snd_pct = ph.snd;
      rcv_pct = ph.rcv;
      if (ph.squeeze) hold_req = hold_req + 1;
      now_ms = $urandom_range(0, 2000);
      for (int n = 0; n < ph.count; n++) send_item(song_item(), 0, '0);
      item_valid <= 1'b0;
    end

    // Drain
    while (gate_exp.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (err_count == 0) begin
      $display("timed_note_gate_scheduler_unit_tb: done, clean");
    end else begin
      $display("timed_note_gate_scheduler_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== timed_note_gate_scheduler_unit.f =====
rtl/tngs_pkg.sv
rtl/tngs_due.sv
rtl/timed_note_gate_scheduler_unit.sv
tb/timed_note_gate_scheduler_unit_tb.sv
